// ===== rtl/gtl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gtl_pkg;

   localparam int MAX_WINDOW  = 4096;
   localparam int SQRT_STEPS  = 47;
   localparam int DIV_STEPS   = 47;

   localparam logic [12:0] MIN_LEN   = 13'd2;
   localparam logic [12:0] MAX_LEN   = 13'(MAX_WINDOW);
   localparam logic [79:0] RND_HALF  = 80'h2000_0000;

   // register indexes
   localparam logic [1:0] REG_TWO_COS = 2'd0;
   localparam logic [1:0] REG_COS     = 2'd1;
   localparam logic [1:0] REG_SIN     = 2'd2;
   localparam logic [1:0] REG_WINDOW  = 2'd3;

   // coefficient select
   localparam logic [1:0] COEF_TWO_COS = 2'd0;
   localparam logic [1:0] COEF_COS     = 2'd1;
   localparam logic [1:0] COEF_SIN     = 2'd2;

   // multiplier operand select
   localparam logic [2:0] MUL_HI = 3'd0;
   localparam logic [2:0] MUL_LO = 3'd1;
   localparam logic [2:0] MUL_RE = 3'd2;
   localparam logic [2:0] MUL_IM = 3'd3;
   localparam logic [2:0] MUL_NN = 3'd4;

   // accumulator operation
   localparam logic [1:0] ACC_HOLD    = 2'd0;
   localparam logic [1:0] ACC_LOAD_HI = 2'd1;
   localparam logic [1:0] ACC_LOAD    = 2'd2;
   localparam logic [1:0] ACC_ADD     = 2'd3;

   typedef struct packed {
      logic       capture;
      logic       prep;
      logic [1:0] coef_sel;
      logic [2:0] mul_src;
      logic [1:0] acc_op;
      logic       fin_step;
      logic       store_re;
      logic       store_im;
      logic       sq_done;
      logic       sqrt_step;
      logic       div_step;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

// ===== rtl/gtl_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface gtl_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

// ===== rtl/gtl_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface gtl_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] rms_level;

   modport source (output valid, output rms_level, input ready);
   modport sink   (input valid, input rms_level, output ready);
endinterface
`default_nettype wire

// ===== rtl/goertzel_tone_level_top.sv =====
// Goertzel tone level meter. Each accepted word carries one Q1.15 sample; the
// last sample of every window of N samples yields one Q2.30 RMS level word.
// A sample inside a window runs through the accept, two partial products on
// the one shared 32x32 multiplier, their rounding sum and the recurrence
// update. The closing sample of a window, with the output register free,
// runs through the accept, three multiplier passes, the squares and the
// overflow bound, a 47-step square root and a 47-step divide by N (one bit
// per cycle each) and the load of the output. If the previous word still
// waits there, the closing sample holds until it is taken. A finished word
// waits in the output register while the next samples are taken.
// Configuration writes take effect at once and never clear the window state.
`timescale 1ns / 1ps
`default_nettype none
module goertzel_tone_level_top (
   input  wire logic        clock,
   input  wire logic        reset,
   gtl_req_if.sink          req_chan,
   gtl_rsp_if.source        rsp_chan,
   input  wire logic        csr_wen,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   import gtl_pkg::*;

   cmd_type cmd;
   sts_type sts;

   gtl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gtl_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_sample    (req_chan.sample),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_rms_level (rsp_chan.rms_level),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

endmodule
`default_nettype wire

// ===== rtl/gtl_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gtl_dp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire gtl_pkg::cmd_type    cmd,
   output gtl_pkg::sts_type         sts,
   input  wire logic signed [15:0]  req_sample,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [31:0]              rsp_rms_level,
   input  wire logic                csr_wen,
   input  wire logic [1:0]          csr_index,
   input  wire logic [31:0]         csr_wdata
);
   import gtl_pkg::*;

   logic signed [31:0] two_cos_ff, cos_ff, sin_ff;
   logic [12:0]        window_ff;

   logic signed [15:0] x_ff;
   logic signed [47:0] s1_ff, s2_ff, s0_ff;
   logic [12:0]        count_ff;
   logic [47:0]        mag_s_ff;
   logic [31:0]        mag_c_ff;
   logic               neg_ff;
   logic [63:0]        mul_ff;
   logic [79:0]        acc_ff, acc_in;
   logic signed [51:0] re_ff, im_ff;
   logic [63:0]        rad_ff;
   logic [49:0]        rem_ff;
   logic [47:0]        root_ff;
   logic [12:0]        dr_ff;
   logic               sat_ff;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_data_ff;

   logic [12:0]        n_eff;
   logic signed [31:0] coef;
   logic [31:0]        op_a, op_b;
   logic [63:0]        prod;
   logic signed [51:0] q52, q_s;
   logic signed [53:0] sum;
   logic signed [47:0] s0_val;
   logic [51:0]        are, aim;
   logic [63:0]        m_val, lim_val;
   logic [49:0]        rem_n, trial;
   logic [13:0]        dr_n;

   always_comb begin
      n_eff = window_ff;
      if (window_ff < MIN_LEN) n_eff = MIN_LEN;
      if (window_ff > MAX_LEN) n_eff = MAX_LEN;
   end

   assign sts.last     = ({1'b0, count_ff} + 14'd1) >= {1'b0, n_eff};
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (cmd.coef_sel)
         COEF_TWO_COS: coef = two_cos_ff;
         COEF_COS:     coef = cos_ff;
         COEF_SIN:     coef = sin_ff;
         default:      coef = two_cos_ff;
      endcase
   end

   assign are = re_ff[51] ? 52'(-re_ff) : 52'(re_ff);
   assign aim = im_ff[51] ? 52'(-im_ff) : 52'(im_ff);

   always_comb begin
      case (cmd.mul_src)
         MUL_HI:  begin op_a = mag_c_ff;   op_b = {8'd0, mag_s_ff[47:24]}; end
         MUL_LO:  begin op_a = mag_c_ff;   op_b = {8'd0, mag_s_ff[23:0]};  end
         MUL_RE:  begin op_a = are[31:0];  op_b = are[31:0];               end
         MUL_IM:  begin op_a = aim[31:0];  op_b = aim[31:0];               end
         MUL_NN:  begin op_a = {19'd0, n_eff}; op_b = {19'd0, n_eff};      end
         default: begin op_a = '0;         op_b = '0;                      end
      endcase
   end
   assign prod = {32'd0, op_a} * {32'd0, op_b};

   always_comb begin
      case (cmd.acc_op)
         ACC_LOAD_HI: acc_in = {mul_ff[55:0], 24'd0} + RND_HALF;
         ACC_LOAD:    acc_in = {16'd0, mul_ff};
         ACC_ADD:     acc_in = acc_ff + {16'd0, mul_ff};
         default:     acc_in = acc_ff;
      endcase
   end

   // rounded product magnitude, sign restored
   assign q52 = $signed({2'b00, acc_ff[79:30]});
   assign q_s = neg_ff ? -q52 : q52;
   assign sum = 54'(x_ff) + 54'(q_s) - 54'(s2_ff);
   always_comb begin
      if (sum > 54'sh7FFF_FFFF_FFFF)       s0_val = 48'sh7FFF_FFFF_FFFF;
      else if (sum < -54'sh8000_0000_0000) s0_val = -48'sh8000_0000_0000;
      else                                 s0_val = sum[47:0];
   end

   assign m_val   = {acc_ff[62:0], 1'b0};
   assign lim_val = {mul_ff[29:0], 34'd0};
   assign rem_n   = {rem_ff[47:0], rad_ff[63:62]};
   assign trial   = {root_ff, 2'b01};
   assign dr_n    = {dr_ff, root_ff[46]};

   always_ff @(posedge clock) begin
      if (reset) begin
         two_cos_ff <= 32'sd0;
         cos_ff     <= 32'sh4000_0000;
         sin_ff     <= 32'sd0;
         window_ff  <= 13'd1024;
      end else if (csr_wen) begin
         case (csr_index)
            REG_TWO_COS: two_cos_ff <= csr_wdata;
            REG_COS:     cos_ff     <= csr_wdata;
            REG_SIN:     sin_ff     <= csr_wdata;
            REG_WINDOW:  window_ff  <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         s2_ff        <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.out_load || (rsp_valid_ff && !rsp_ready);
         if (cmd.fin_step && !sts.last) begin
            s2_ff    <= s1_ff;
            s1_ff    <= s0_val;
            count_ff <= count_ff + 13'd1;
         end
         if (cmd.out_load) begin
            s1_ff        <= '0;
            s2_ff        <= '0;
            count_ff     <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= prod;
      acc_ff <= acc_in;
      if (cmd.capture) x_ff <= req_sample;
      if (cmd.prep) begin
         mag_s_ff <= s1_ff[47] ? 48'(-s1_ff) : 48'(s1_ff);
         mag_c_ff <= coef[31] ? 32'(-coef) : 32'(coef);
         neg_ff   <= s1_ff[47] ^ coef[31];
      end
      if (cmd.fin_step && sts.last) s0_ff <= s0_val;
      if (cmd.store_re) re_ff <= 52'(s0_ff) - q_s;
      if (cmd.store_im) im_ff <= q_s;
      if (cmd.sq_done) begin
         rad_ff  <= m_val;
         rem_ff  <= '0;
         root_ff <= '0;
         dr_ff   <= '0;
         sat_ff  <= (|are[51:31]) || (|aim[51:31]) || (m_val >= lim_val);
      end
      if (cmd.sqrt_step) begin
         rad_ff <= {rad_ff[61:0], 2'b00};
         if (rem_n >= trial) begin
            rem_ff  <= rem_n - trial;
            root_ff <= {root_ff[46:0], 1'b1};
         end else begin
            rem_ff  <= rem_n;
            root_ff <= {root_ff[46:0], 1'b0};
         end
      end
      // shift quotient bits into the root register as the dividend drains
      if (cmd.div_step) begin
         if (dr_n >= {1'b0, n_eff}) begin
            dr_ff   <= 13'(dr_n - {1'b0, n_eff});
            root_ff <= {root_ff[46:0], 1'b1};
         end else begin
            dr_ff   <= dr_n[12:0];
            root_ff <= {root_ff[46:0], 1'b0};
         end
      end
      // bit 47 holds a leftover dividend bit; the quotient sits in 46:0
      if (cmd.out_load)
         rsp_data_ff <= (sat_ff || (|root_ff[46:32])) ? 32'hFFFF_FFFF : root_ff[31:0];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rms_level = rsp_data_ff;

endmodule
`default_nettype wire

// ===== rtl/gtl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gtl_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire gtl_pkg::sts_type sts,
   output gtl_pkg::cmd_type      cmd
);
   import gtl_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_HI   = 4'd1;
   localparam logic [3:0] S_LO   = 4'd2;
   localparam logic [3:0] S_ADD  = 4'd3;
   localparam logic [3:0] S_FIN  = 4'd4;
   localparam logic [3:0] S_SQA  = 4'd5;
   localparam logic [3:0] S_SQB  = 4'd6;
   localparam logic [3:0] S_SQC  = 4'd7;
   localparam logic [3:0] S_SQD  = 4'd8;
   localparam logic [3:0] S_SQRT = 4'd9;
   localparam logic [3:0] S_DIV  = 4'd10;
   localparam logic [3:0] S_OUT  = 4'd11;

   localparam logic [1:0] PH_REC = 2'd0;
   localparam logic [1:0] PH_COS = 2'd1;
   localparam logic [1:0] PH_SIN = 2'd2;

   localparam logic [5:0] SQRT_LAST = 6'(SQRT_STEPS - 1);
   localparam logic [5:0] DIV_LAST  = 6'(DIV_STEPS - 1);

   logic [3:0] state_ff, state_in;
   logic [1:0] ph_ff, ph_in;
   logic [5:0] iter_ff, iter_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      ph_in    = ph_ff;
      iter_in  = iter_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture  = 1'b1;
               cmd.prep     = 1'b1;
               cmd.coef_sel = COEF_TWO_COS;
               ph_in        = PH_REC;
               state_in     = S_HI;
            end
         end
         S_HI: begin
            cmd.mul_src = MUL_HI;
            state_in    = S_LO;
         end
         S_LO: begin
            cmd.mul_src = MUL_LO;
            cmd.acc_op  = ACC_LOAD_HI;
            state_in    = S_ADD;
         end
         S_ADD: begin
            cmd.acc_op = ACC_ADD;
            state_in   = S_FIN;
         end
         S_FIN: begin
            case (ph_ff)
               PH_REC: begin
                  cmd.fin_step = 1'b1;
                  if (sts.last) begin
                     cmd.prep     = 1'b1;
                     cmd.coef_sel = COEF_COS;
                     ph_in        = PH_COS;
                     state_in     = S_HI;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               PH_COS: begin
                  cmd.store_re = 1'b1;
                  cmd.prep     = 1'b1;
                  cmd.coef_sel = COEF_SIN;
                  ph_in        = PH_SIN;
                  state_in     = S_HI;
               end
               PH_SIN: begin
                  cmd.store_im = 1'b1;
                  state_in     = S_SQA;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_SQA: begin
            cmd.mul_src = MUL_RE;
            state_in    = S_SQB;
         end
         S_SQB: begin
            cmd.mul_src = MUL_IM;
            cmd.acc_op  = ACC_LOAD;
            state_in    = S_SQC;
         end
         S_SQC: begin
            cmd.mul_src = MUL_NN;
            cmd.acc_op  = ACC_ADD;
            state_in    = S_SQD;
         end
         S_SQD: begin
            cmd.sq_done = 1'b1;
            iter_in     = '0;
            state_in    = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            iter_in       = iter_ff + 6'd1;
            if (iter_ff == SQRT_LAST) begin
               iter_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            iter_in      = iter_ff + 6'd1;
            if (iter_ff == DIV_LAST) begin
               iter_in  = '0;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the output register can take the word
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ph_ff    <= PH_REC;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         iter_ff  <= iter_in;
      end
   end

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result loaded while output register busy");

   a_sqrt_to_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQRT && iter_ff == SQRT_LAST) |=> state_ff == S_DIV)
      else $error("square root did not hand over to divider");

   a_fin_after_add: assert property (@(posedge clock) disable iff (reset)
      cmd.fin_step |-> $past(state_ff) == S_ADD)
      else $error("recurrence committed before product finished");

endmodule
`default_nettype wire
